// File: design/multi_axis_linear_interpolator_unit_macros.svh
// Assertion macros used by the checker file (mali_checker.sv).
`ifndef MULTI_AXIS_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define MULTI_AXIS_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define MALI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mali checker: same-cycle rule violated");

// Next-cycle implication, sampled on clock, off while reset is high.
`define MALI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mali checker: next-cycle rule violated");

`endif

// File: design/mali_pkg.sv
`timescale 1ns / 1ps

package mali_pkg;

   localparam int AXES   = 4;
   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

   localparam logic [15:0] GEAR_RESET = 16'd100;
   localparam logic [31:0] GEAR_SCALE = 32'd100;
   localparam logic [31:0] COUNT_SAT  = 32'hFFFF_FFFF;

   // operation codes
   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_STEP = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOAXIS = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_AXIS,
      ST_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_FIN
   } md_state_type;

   typedef struct packed {
      logic done;
      logic rem_nz;
   } md_status_type;

endpackage

// File: design/mali_muldiv.sv
`timescale 1ns / 1ps

// Bit-serial multiply then divide: quotient = mag * mult / divisor.
// Steps: shift-add multiply (MD_MUL), restoring division (MD_DIV), then MD_FIN reports.
module mali_muldiv (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            mag,
   input  logic [31:0]            mult,
   input  logic [31:0]            divisor,
   output logic [63:0]            quotient,
   output mali_pkg::md_status_type stat
);

   mali_pkg::md_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] div_ff, div_in;

   logic [32:0] add_sum;
   logic [32:0] rshift;
   logic [32:0] rdiff;
   logic        ge;

   // one digit of each operation
   always_comb begin
      add_sum = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, mag_ff} : 33'd0);
      rshift  = {rem_ff, prod_ff[63]};
      rdiff   = rshift - {1'b0, div_ff};
      ge      = (rshift >= {1'b0, div_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mali_pkg::MD_IDLE: if (start) state_in = mali_pkg::MD_MUL;
         mali_pkg::MD_MUL:  if (cnt_ff[4:0] == 5'd31) state_in = mali_pkg::MD_DIV;
         mali_pkg::MD_DIV:  if (cnt_ff == 6'd63) state_in = mali_pkg::MD_FIN;
         mali_pkg::MD_FIN:  state_in = mali_pkg::MD_IDLE;
         default:           state_in = mali_pkg::MD_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      div_in  = div_ff;
      unique case (state_ff)
         mali_pkg::MD_IDLE: begin
            if (start) begin
               cnt_in  = 6'd0;
               prod_in = {32'd0, mult};
               rem_in  = 32'd0;
               mag_in  = mag;
               div_in  = divisor;
            end
         end
         mali_pkg::MD_MUL: begin
            prod_in = {add_sum[32:1], add_sum[0], prod_ff[31:1]};
            cnt_in  = (cnt_ff[4:0] == 5'd31) ? 6'd0 : cnt_ff + 6'd1;
         end
         mali_pkg::MD_DIV: begin
            rem_in  = ge ? rdiff[31:0] : rshift[31:0];
            prod_in = {prod_ff[62:0], ge};
            cnt_in  = cnt_ff + 6'd1;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      quotient    = prod_ff;
      stat.done   = (state_ff == mali_pkg::MD_FIN);
      stat.rem_nz = |rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mali_pkg::MD_IDLE;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      mag_ff  <= mag_in;
      div_ff  <= div_in;
   end

endmodule

// File: design/multi_axis_linear_interpolator_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake             | Payload
// req     | in  | req_valid / req_ready | req_opcode, req_target_axis0..3
// rsp     | out | rsp_valid / rsp_ready | rsp_point_axis0..3, valid, last, count, status
// csr     | in  | csr_valid / csr_ready | csr_index, csr_data (gear registers)
//
// Set and rejected operations go from ST_IDLE straight to ST_RESP, which loads the
// response register once the previous response has been taken or none is pending.
// Load and step run the axes one after another through one bit-serial
// multiply-divide unit (ST_AXIS, then ST_WAIT; a skipped axis uses ST_AXIS
// only), and no new word is taken until the response register is loaded.
// A load skips axes with zero gear. Reset is synchronous; gears reset to 100.
// A new word is taken while the previous response still waits on rsp_ready.
module multi_axis_linear_interpolator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic signed [31:0] req_target_axis0,
   input  logic signed [31:0] req_target_axis1,
   input  logic signed [31:0] req_target_axis2,
   input  logic signed [31:0] req_target_axis3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_point_axis0,
   output logic signed [31:0] rsp_point_axis1,
   output logic signed [31:0] rsp_point_axis2,
   output logic signed [31:0] rsp_point_axis3,
   output logic        rsp_point_valid,
   output logic        rsp_last_point,
   output logic [31:0] rsp_point_count,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AXES   = mali_pkg::AXES;
   localparam int AXIS_W = mali_pkg::AXIS_W;

   mali_pkg::state_type state_ff, state_in;

   logic [15:0] gear_ff [AXES];
   logic [31:0] start_ff [AXES];
   logic [31:0] start_in [AXES];
   logic [31:0] end_ff [AXES];
   logic [31:0] end_in [AXES];
   logic [31:0] tgt_ff [AXES];
   logic [31:0] tgt_in [AXES];
   logic [31:0] res_pt_ff [AXES];
   logic [31:0] res_pt_in [AXES];
   logic [31:0] req_tgt [AXES];

   logic [31:0] seg_ff, seg_in;
   logic [31:0] idx_ff, idx_in;
   logic        active_ff, active_in;
   logic [1:0]  op_ff, op_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic [31:0] best_ff, best_in;
   logic        any_ff, any_in;
   logic        res_valid_ff, res_valid_in;
   logic        res_last_ff, res_last_in;
   logic [1:0]  res_status_ff, res_status_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_pt_ff [AXES];
   logic        rsp_pv_ff, rsp_last_ff;
   logic [31:0] rsp_count_ff;
   logic [1:0]  rsp_status_ff;

   logic        req_acc;
   logic        axis_skip;
   logic        axis_last;
   logic        fin;
   logic        out_load;
   logic        md_start;
   logic [32:0] idx_inc;

   // per-axis operands
   logic signed [32:0] diff;
   logic [32:0] diff_abs;
   logic [31:0] mag;
   logic [31:0] mult;
   logic [31:0] divisor;
   logic [63:0] quot;
   mali_pkg::md_status_type md_stat;
   logic [31:0] count_ax;
   logic signed [32:0] base;
   logic signed [32:0] base_adj;

   assign req_tgt[0] = req_target_axis0;
   assign req_tgt[1] = req_target_axis1;
   assign req_tgt[2] = req_target_axis2;
   assign req_tgt[3] = req_target_axis3;

   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign axis_skip = (op_ff == mali_pkg::OP_LOAD) && (gear_ff[axis_ff] == 16'd0);
   assign axis_last = (axis_ff == AXIS_W'(AXES - 1));
   assign idx_inc   = {1'b0, idx_ff} + 33'd1;

   // operand selection for the current axis
   always_comb begin
      logic [31:0] e;
      e        = (op_ff == mali_pkg::OP_LOAD) ? tgt_ff[axis_ff] : end_ff[axis_ff];
      diff     = $signed({e[31], e}) - $signed({start_ff[axis_ff][31], start_ff[axis_ff]});
      diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
      mag      = diff_abs[31:0];
      mult     = (op_ff == mali_pkg::OP_LOAD) ? mali_pkg::GEAR_SCALE : idx_ff;
      divisor  = (op_ff == mali_pkg::OP_LOAD) ? {16'd0, gear_ff[axis_ff]} : seg_ff;
   end

   mali_muldiv u_md (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mag      (mag),
      .mult     (mult),
      .divisor  (divisor),
      .quotient (quot),
      .stat     (md_stat)
   );

   // axis result: saturated count for load, truncated point for step
   always_comb begin
      count_ax = (|quot[63:32]) ? mali_pkg::COUNT_SAT : quot[31:0];
      if (diff[32]) begin
         base     = $signed({start_ff[axis_ff][31], start_ff[axis_ff]}) - $signed({1'b0, quot[31:0]});
         base_adj = (md_stat.rem_nz && !base[32] && (base != 33'sd0)) ? base - 33'sd1 : base;
      end else begin
         base     = $signed({start_ff[axis_ff][31], start_ff[axis_ff]}) + $signed({1'b0, quot[31:0]});
         base_adj = (md_stat.rem_nz && base[32]) ? base + 33'sd1 : base;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mali_pkg::ST_IDLE: begin
            if (req_acc) begin
               if ((req_opcode == mali_pkg::OP_LOAD && !active_ff) ||
                   (req_opcode == mali_pkg::OP_STEP && active_ff && seg_ff != 32'd0))
                  state_in = mali_pkg::ST_AXIS;
               else
                  state_in = mali_pkg::ST_RESP;
            end
         end
         mali_pkg::ST_AXIS: begin
            if (!axis_skip)     state_in = mali_pkg::ST_WAIT;
            else if (axis_last) state_in = mali_pkg::ST_RESP;
         end
         mali_pkg::ST_WAIT: begin
            if (md_stat.done)
               state_in = axis_last ? mali_pkg::ST_RESP : mali_pkg::ST_AXIS;
         end
         mali_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = mali_pkg::ST_IDLE;
         end
         default: state_in = mali_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == mali_pkg::ST_IDLE);
      md_start  = (state_ff == mali_pkg::ST_AXIS) && !axis_skip;
      out_load  = (state_ff == mali_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);
      fin       = axis_last &&
                  (((state_ff == mali_pkg::ST_AXIS) && axis_skip) ||
                   ((state_ff == mali_pkg::ST_WAIT) && md_stat.done));
   end

   // datapath
   always_comb begin
      start_in      = start_ff;
      end_in        = end_ff;
      tgt_in        = tgt_ff;
      res_pt_in     = res_pt_ff;
      seg_in        = seg_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      op_in         = op_ff;
      axis_in       = axis_ff;
      best_in       = best_ff;
      any_in        = any_ff;
      res_valid_in  = res_valid_ff;
      res_last_in   = res_last_ff;
      res_status_in = res_status_ff;

      // word accepted
      if (state_ff == mali_pkg::ST_IDLE && req_acc) begin
         op_in         = req_opcode;
         tgt_in        = req_tgt;
         axis_in       = '0;
         best_in       = 32'd0;
         any_in        = 1'b0;
         res_valid_in  = 1'b0;
         res_last_in   = 1'b0;
         res_status_in = mali_pkg::STAT_OK;
         for (int k = 0; k < AXES; k++) res_pt_in[k] = 32'd0;
         case (req_opcode)
            mali_pkg::OP_SET: begin
               if (active_ff) res_status_in = mali_pkg::STAT_REJECT;
               else           start_in = req_tgt;
            end
            mali_pkg::OP_LOAD: begin
               if (active_ff) res_status_in = mali_pkg::STAT_REJECT;
            end
            mali_pkg::OP_STEP: begin
               if (!active_ff || seg_ff == 32'd0) begin
                  active_in     = 1'b0;
                  res_status_in = mali_pkg::STAT_REJECT;
               end else begin
                  idx_in = (idx_inc > {1'b0, seg_ff}) ? seg_ff : idx_inc[31:0];
               end
            end
            default: res_status_in = mali_pkg::STAT_REJECT;
         endcase
      end

      // axis skipped
      if (state_ff == mali_pkg::ST_AXIS && axis_skip && !axis_last)
         axis_in = axis_ff + AXIS_W'(1);

      // axis finished
      if (state_ff == mali_pkg::ST_WAIT && md_stat.done) begin
         if (op_ff == mali_pkg::OP_LOAD) begin
            any_in = 1'b1;
            if (count_ax > best_ff) best_in = count_ax;
         end else begin
            res_pt_in[axis_ff] = base_adj[31:0];
         end
         if (!axis_last) axis_in = axis_ff + AXIS_W'(1);
      end

      // segment bookkeeping after the last axis
      if (fin) begin
         if (op_ff == mali_pkg::OP_LOAD) begin
            if (!any_in) begin
               res_status_in = mali_pkg::STAT_NOAXIS;
            end else begin
               seg_in = best_in;
               idx_in = 32'd0;
               end_in = tgt_ff;
               if (best_in == 32'd0) start_in  = tgt_ff;
               else                  active_in = 1'b1;
            end
         end else begin
            res_valid_in = 1'b1;
            if (idx_ff == seg_ff) begin
               res_last_in = 1'b1;
               active_in   = 1'b0;
               start_in    = end_ff;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mali_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         seg_ff       <= 32'd0;
         idx_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < AXES; k++) begin
            start_ff[k] <= 32'd0;
            end_ff[k]   <= 32'd0;
            gear_ff[k]  <= mali_pkg::GEAR_RESET;
         end
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         seg_ff    <= seg_in;
         idx_ff    <= idx_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         if (out_load)                    rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready && ({24'd0, csr_index} < AXES))
            gear_ff[csr_index[AXIS_W-1:0]] <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      res_pt_ff     <= res_pt_in;
      op_ff         <= op_in;
      axis_ff       <= axis_in;
      best_ff       <= best_in;
      any_ff        <= any_in;
      res_valid_ff  <= res_valid_in;
      res_last_ff   <= res_last_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_pt_ff     <= res_pt_ff;
         rsp_pv_ff     <= res_valid_ff;
         rsp_last_ff   <= res_last_ff;
         rsp_count_ff  <= seg_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_axis0 = rsp_pt_ff[0];
   assign rsp_point_axis1 = rsp_pt_ff[1];
   assign rsp_point_axis2 = rsp_pt_ff[2];
   assign rsp_point_axis3 = rsp_pt_ff[3];
   assign rsp_point_valid = rsp_pv_ff;
   assign rsp_last_point  = rsp_last_ff;
   assign rsp_point_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// File: design/mali_checker.sv
`timescale 1ns / 1ps
`include "multi_axis_linear_interpolator_unit_macros.svh"

// Port-level checks of the response channel.
module mali_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_point_axis0,
   input logic [31:0] rsp_point_axis1,
   input logic [31:0] rsp_point_axis2,
   input logic [31:0] rsp_point_axis3,
   input logic        rsp_point_valid,
   input logic        rsp_last_point,
   input logic [1:0]  rsp_status
);

   logic pts_zero;

   assign pts_zero = (rsp_point_axis0 == 32'd0) && (rsp_point_axis1 == 32'd0) &&
                     (rsp_point_axis2 == 32'd0) && (rsp_point_axis3 == 32'd0);

   // a stalled response stays up
   `MALI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // no point means all axes read zero
   `MALI_ASSERT_IMP(a_zero_pts, rsp_valid && !rsp_point_valid, pts_zero)
   // last flag only rides on a point
   `MALI_ASSERT_IMP(a_last_pt, rsp_valid && rsp_last_point, rsp_point_valid)
   // an error status carries no point
   `MALI_ASSERT_IMP(a_err_nopt, rsp_valid && (rsp_status != mali_pkg::STAT_OK), !rsp_point_valid)
   // unused status code never shows
   `MALI_ASSERT_IMP(a_stat_code, rsp_valid, rsp_status <= mali_pkg::STAT_REJECT)

endmodule

bind multi_axis_linear_interpolator_unit mali_checker u_mali_checker (.*);
